// File: src/srl_pkg.sv
package srl_pkg;

   // Defaults for the top-level parameters
   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int MAX_RUN_DEF     = 64;

   // Field widths of the request and response channels
   localparam int OP_W     = 3;
   localparam int GROUP_W  = 8;
   localparam int INDEX_W  = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 10;
   localparam int KEY_W    = 2 * GROUP_W + INDEX_W;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_FWD  = 3'd0,
      OP_LOAD_REV  = 3'd1,
      OP_QUERY_FWD = 3'd2,
      OP_QUERY_REV = 3'd3,
      OP_CLEAR     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // One relation entry as stored in the table memory
   typedef struct packed {
      logic [GROUP_W-1:0] ga;
      logic [GROUP_W-1:0] gb;
      logic [INDEX_W-1:0] ia;
      logic [INDEX_W-1:0] ib;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Forward ordering: source group, source index, target group
   function automatic logic [KEY_W-1:0] fwd_key(input entry_type e);
      return {e.ga, e.ia, e.gb};
   endfunction

   // Reverse ordering: target group, target index, source group
   function automatic logic [KEY_W-1:0] rev_key(input entry_type e);
      return {e.gb, e.ib, e.ga};
   endfunction

endpackage

// File: src/srl_req_if.sv
interface srl_req_if
   import srl_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [GROUP_W-1:0] group_a;
   logic [GROUP_W-1:0] group_b;
   logic [INDEX_W-1:0] index_a;
   logic [INDEX_W-1:0] index_b;

   modport source (output valid, op, group_a, group_b, index_a, index_b, input ready);
   modport sink   (input valid, op, group_a, group_b, index_a, index_b, output ready);
endinterface

// File: src/srl_rsp_if.sv
interface srl_rsp_if
   import srl_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [GROUP_W-1:0]  group_out;
   logic [INDEX_W-1:0]  index_out;
   logic [SLOT_W-1:0]   slot;
   logic                last;
   logic                truncated;

   modport source (output valid, status, group_out, index_out, slot, last, truncated,
                   input ready);
   modport sink   (input valid, status, group_out, index_out, slot, last, truncated,
                   output ready);
endinterface

// File: src/srl_ram.sv
module srl_ram #(
   parameter int DATA_W = 48,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, hold data while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/sorted_relation_lookup.sv
// A load or clear request is decoded, then its response is loaded into the response
// register once that register is free. A query runs a binary search of at most
// ceil(log2(count + 1)) steps, one table memory read each, a read to verify the lower
// bound, then one response per result; a miss past the last entry skips the verify.
// Throughput: one request at a time; the next is accepted once the last response is queued.
// Reset: both entry counts clear to zero; table contents are left undefined, no clearing pass.
module sorted_relation_lookup
   import srl_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_RUN     = MAX_RUN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   srl_req_if.sink   req_if,
   srl_rsp_if.source rsp_if
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int NW = $clog2(MAX_RUN + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_PROBE,
      ST_VERIFY,
      ST_RUN_RD,
      ST_RUN_CMP
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   entry_type           req_entry_ff, req_entry_in;
   logic                rev_ff, rev_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [CW-1:0]       fcount_ff, fcount_in;
   logic [CW-1:0]       rcount_ff, rcount_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       mid_ff, mid_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [NW-1:0]       run_cnt_ff, run_cnt_in;
   entry_type           pend_ff, pend_in;
   logic [CW-1:0]       pend_pos_ff, pend_pos_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [GROUP_W-1:0]  rsp_group_ff, rsp_group_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_trunc_ff, rsp_trunc_in;

   // Response staging from the sequencer
   logic                emit;
   status_type          e_status;
   logic [GROUP_W-1:0]  e_group;
   logic [INDEX_W-1:0]  e_index;
   logic [CW-1:0]       e_slot;
   logic                e_last;
   logic                e_trunc;

   logic                out_free;
   logic [CW-1:0]       count_sel;
   logic [CW-1:0]       mid;
   logic [CW-1:0]       rd_idx;
   logic [CW-1:0]       wr_idx;
   logic                ram_we;
   logic                ram_re;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           rd_entry;
   logic [KEY_W-1:0]    rd_key;
   logic                run_match;

   // Table memory: forward table in the lower half, reverse table in the upper half
   srl_ram #(
      .DATA_W (ENTRY_W),
      .ADDR_W (AW + 1)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr ({rev_ff, wr_idx[AW-1:0]}),
      .wr_data (req_entry_ff),
      .rd_en   (ram_re),
      .rd_addr ({rev_ff, rd_idx[AW-1:0]}),
      .rd_data (ram_rdata)
   );

   assign rd_entry  = entry_type'(ram_rdata);
   assign rd_key    = rev_ff ? rev_key(rd_entry) : fwd_key(rd_entry);
   assign run_match = rev_ff ? (rd_entry.gb == pend_ff.gb && rd_entry.ib == pend_ff.ib)
                             : (rd_entry.ga == pend_ff.ga && rd_entry.ia == pend_ff.ia);
   assign count_sel = rev_ff ? rcount_ff : fcount_ff;
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign out_free  = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.group_out = rsp_group_ff;
   assign rsp_if.index_out = rsp_index_ff;
   assign rsp_if.slot      = rsp_slot_ff;
   assign rsp_if.last      = rsp_last_ff;
   assign rsp_if.truncated = rsp_trunc_ff;

   // Sequencer: decode, binary search, run scan
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      req_entry_in = req_entry_ff;
      rev_in       = rev_ff;
      key_in       = key_ff;
      fcount_in    = fcount_ff;
      rcount_in    = rcount_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      run_cnt_in   = run_cnt_ff;
      pend_in      = pend_ff;
      pend_pos_in  = pend_pos_ff;
      emit         = 1'b0;
      e_status     = STATUS_OK;
      e_group      = '0;
      e_index      = '0;
      e_slot       = '0;
      e_last       = 1'b1;
      e_trunc      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      rd_idx       = pos_ff;
      wr_idx       = count_sel;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               op_in        = op_type'(req_if.op);
               req_entry_in = '{ga: req_if.group_a, gb: req_if.group_b,
                                ia: req_if.index_a, ib: req_if.index_b};
               rev_in       = (op_type'(req_if.op) == OP_LOAD_REV) ||
                              (op_type'(req_if.op) == OP_QUERY_REV);
               state_in     = ST_DECODE;
            end
         end

         ST_DECODE: begin
            unique case (op_ff) inside
               OP_LOAD_FWD, OP_LOAD_REV: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     state_in = ST_IDLE;
                     if (count_sel >= CW'(TABLE_DEPTH)) begin
                        e_status = STATUS_FULL;
                     end else begin
                        ram_we = 1'b1;
                        e_slot = count_sel;
                        if (rev_ff) begin
                           rcount_in = rcount_ff + CW'(1);
                        end else begin
                           fcount_in = fcount_ff + CW'(1);
                        end
                     end
                  end
               end
               OP_CLEAR: begin
                  if (out_free) begin
                     emit      = 1'b1;
                     fcount_in = '0;
                     rcount_in = '0;
                     state_in  = ST_IDLE;
                  end
               end
               OP_QUERY_FWD, OP_QUERY_REV: begin
                  lo_in    = '0;
                  hi_in    = count_sel;
                  key_in   = rev_ff ? rev_key(req_entry_ff) : fwd_key(req_entry_ff);
                  state_in = ST_SEARCH;
               end
               default: begin
                  // unused codes: drop the request
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               ram_re   = 1'b1;
               rd_idx   = mid;
               mid_in   = mid;
               state_in = ST_PROBE;
            end else if (lo_ff >= count_sel) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_status = STATUS_NOT_FOUND;
                  e_slot   = lo_ff;
                  state_in = ST_IDLE;
               end
            end else begin
               ram_re   = 1'b1;
               rd_idx   = lo_ff;
               state_in = ST_VERIFY;
            end
         end

         ST_PROBE: begin
            if (rd_key < key_ff) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SEARCH;
         end

         ST_VERIFY: begin
            if (rd_key != key_ff) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_status = STATUS_NOT_FOUND;
                  e_slot   = lo_ff;
                  state_in = ST_IDLE;
               end
            end else begin
               // hold the first match until the next entry decides its last flag
               pend_in     = rd_entry;
               pend_pos_in = lo_ff;
               pos_in      = lo_ff + CW'(1);
               run_cnt_in  = NW'(1);
               state_in    = ST_RUN_RD;
            end
         end

         ST_RUN_RD: begin
            if (pos_ff < count_sel) begin
               ram_re   = 1'b1;
               rd_idx   = pos_ff;
               state_in = ST_RUN_CMP;
            end else if (out_free) begin
               emit     = 1'b1;
               e_group  = rev_ff ? pend_ff.ga : pend_ff.gb;
               e_index  = rev_ff ? pend_ff.ia : pend_ff.ib;
               e_slot   = pend_pos_ff;
               state_in = ST_IDLE;
            end
         end

         ST_RUN_CMP: begin
            if (out_free) begin
               emit    = 1'b1;
               e_group = rev_ff ? pend_ff.ga : pend_ff.gb;
               e_index = rev_ff ? pend_ff.ia : pend_ff.ib;
               e_slot  = pend_pos_ff;
               if (run_match && run_cnt_ff < NW'(MAX_RUN)) begin
                  // advance along the run
                  e_last      = 1'b0;
                  pend_in     = rd_entry;
                  pend_pos_in = pos_ff;
                  pos_in      = pos_ff + CW'(1);
                  run_cnt_in  = run_cnt_ff + NW'(1);
                  state_in    = ST_RUN_RD;
               end else begin
                  e_trunc  = run_match;
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_group_in  = rsp_group_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_trunc_in  = rsp_trunc_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = e_status;
         rsp_group_in  = e_group;
         rsp_index_in  = e_index;
         rsp_slot_in   = SLOT_W'(e_slot);
         rsp_last_in   = e_last;
         rsp_trunc_in  = e_trunc;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fcount_ff    <= '0;
         rcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fcount_ff    <= fcount_in;
         rcount_ff    <= rcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      req_entry_ff  <= req_entry_in;
      rev_ff        <= rev_in;
      key_ff        <= key_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      pos_ff        <= pos_in;
      run_cnt_ff    <= run_cnt_in;
      pend_ff       <= pend_in;
      pend_pos_ff   <= pend_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_group_ff  <= rsp_group_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_trunc_ff  <= rsp_trunc_in;
   end
endmodule

// File: src/srl_checker.sv
module srl_checker
   import srl_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [GROUP_W-1:0]  rsp_group_out,
   input logic [INDEX_W-1:0]  rsp_index_out,
   input logic [SLOT_W-1:0]   rsp_slot,
   input logic                rsp_last,
   input logic                rsp_truncated
);
   // A stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
         && $stable(rsp_group_out) && $stable(rsp_index_out) && $stable(rsp_last))
      else $error("response changed while stalled");

   // One request at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A miss is a single, final response
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NOT_FOUND |-> rsp_last && !rsp_truncated)
      else $error("not-found response is not final");

   // Truncation only marks the final response of a match run
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_last && rsp_status == STATUS_OK)
      else $error("truncated flag on a non-final response");

   // A full table returns an empty, final response
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_last && rsp_slot == '0 && rsp_group_out == '0 && rsp_index_out == '0)
      else $error("table-full response carries data");
endmodule

bind sorted_relation_lookup srl_checker u_srl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_group_out (rsp_if.group_out),
   .rsp_index_out (rsp_if.index_out),
   .rsp_slot      (rsp_if.slot),
   .rsp_last      (rsp_if.last),
   .rsp_truncated (rsp_if.truncated)
);

// File: tb/sv/srl_lookup_checker.sv
module srl_lookup_checker
   import srl_pkg::*;
(
   input  logic clock,
   input  logic reset,
   srl_req_if   req_mon,
   srl_rsp_if   rsp_mon,
   output int   mismatches,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type         status;
      logic [GROUP_W-1:0] group;
      logic [INDEX_W-1:0] index;
      logic [SLOT_W-1:0]  slot;
      logic               last;
      logic               truncated;
   } lookup_result;

   // Shadow copy of both relation tables and their fill levels
   entry_type    fwd_rows [TABLE_DEPTH_DEF];
   entry_type    rev_rows [TABLE_DEPTH_DEF];
   int unsigned  fwd_used;
   int unsigned  rev_used;
   lookup_result awaited [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Sort order: source-first for the forward table, target-first for the reverse one
   function automatic logic [KEY_W-1:0] sort_key(entry_type e, bit by_target);
      if (by_target) return {e.gb, e.ib, e.ga};
      return {e.ga, e.ia, e.gb};
   endfunction

   function automatic entry_type row_at(bit by_target, int unsigned pos);
      return by_target ? rev_rows[pos] : fwd_rows[pos];
   endfunction

   function automatic bit in_run(entry_type e, entry_type head, bit by_target);
      if (by_target) return e.gb == head.gb && e.ib == head.ib;
      return e.ga == head.ga && e.ia == head.ia;
   endfunction

   function automatic void queue_result(status_type status, logic [GROUP_W-1:0] group,
                                        logic [INDEX_W-1:0] index, logic [SLOT_W-1:0] slot,
                                        logic last);
      lookup_result r;
      r.status    = status;
      r.group     = group;
      r.index     = index;
      r.slot      = slot;
      r.last      = last;
      r.truncated = 1'b0;
      awaited.push_back(r);
   endfunction

   // Append an entry, or report the table as full
   function automatic void predict_load(bit by_target, entry_type e);
      int unsigned used;
      used = by_target ? rev_used : fwd_used;
      if (used >= TABLE_DEPTH_DEF) begin
         queue_result(STATUS_FULL, '0, '0, '0, 1'b1);
      end else begin
         if (by_target) begin
            rev_rows[used] = e;
            rev_used       = used + 1;
         end else begin
            fwd_rows[used] = e;
            fwd_used       = used + 1;
         end
         queue_result(STATUS_OK, '0, '0, used[SLOT_W-1:0], 1'b1);
      end
   endfunction

   // Lower-bound search, then walk the run of matching entries
   function automatic void predict_query(bit by_target, entry_type probe);
      logic [KEY_W-1:0] want;
      entry_type        head;
      entry_type        row;
      int unsigned      used;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      int unsigned      pos;
      int unsigned      n;
      used = by_target ? rev_used : fwd_used;
      want = sort_key(probe, by_target);
      lo   = 0;
      hi   = used;
      while (lo < hi) begin
         mid = lo + ((hi - lo) >> 1);
         if (sort_key(row_at(by_target, mid), by_target) < want) lo = mid + 1;
         else hi = mid;
      end
      if (lo >= used || sort_key(row_at(by_target, lo), by_target) != want) begin
         queue_result(STATUS_NOT_FOUND, '0, '0, lo[SLOT_W-1:0], 1'b1);
         return;
      end
      head = row_at(by_target, lo);
      pos  = lo;
      n    = 0;
      while (pos < used && n < MAX_RUN_DEF && in_run(row_at(by_target, pos), head, by_target)) begin
         row = row_at(by_target, pos);
         if (by_target) queue_result(STATUS_OK, row.ga, row.ia, pos[SLOT_W-1:0], 1'b0);
         else queue_result(STATUS_OK, row.gb, row.ib, pos[SLOT_W-1:0], 1'b0);
         pos++;
         n++;
      end
      awaited[awaited.size()-1].last = 1'b1;
      // Flag the cut when a further match was left behind
      if (pos < used && in_run(row_at(by_target, pos), head, by_target))
         awaited[awaited.size()-1].truncated = 1'b1;
   endfunction

   function automatic void predict_request();
      entry_type probe;
      probe.ga = req_mon.group_a;
      probe.gb = req_mon.group_b;
      probe.ia = req_mon.index_a;
      probe.ib = req_mon.index_b;
      case (req_mon.op)
         OP_LOAD_FWD:  predict_load(1'b0, probe);
         OP_LOAD_REV:  predict_load(1'b1, probe);
         OP_QUERY_FWD: predict_query(1'b0, probe);
         OP_QUERY_REV: predict_query(1'b1, probe);
         OP_CLEAR: begin
            fwd_used = 0;
            rev_used = 0;
            queue_result(STATUS_OK, '0, '0, '0, 1'b1);
         end
         default: ; // spare codes leave everything alone
      endcase
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_response();
      lookup_result want;
      if (awaited.size() == 0) begin
         $error("response with none awaited: status %0d group_out %0d index_out %0d slot %0d",
                rsp_mon.status, rsp_mon.group_out, rsp_mon.index_out, rsp_mon.slot);
         mismatches++;
         return;
      end
      want = awaited.pop_front();
      compare_field("status", want.status, rsp_mon.status);
      compare_field("group_out", want.group, rsp_mon.group_out);
      compare_field("index_out", want.index, rsp_mon.index_out);
      compare_field("slot", want.slot, rsp_mon.slot);
      compare_field("last", want.last, rsp_mon.last);
      compare_field("truncated", want.truncated, rsp_mon.truncated);
   endfunction

   // Check responses against the oldest prediction, then predict the new request
   always @(posedge clock) begin
      if (reset) begin
         fwd_used = 0;
         rev_used = 0;
         awaited.delete();
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_response();
         if (req_mon.valid && req_mon.ready) predict_request();
         outstanding <= awaited.size();
      end
   end

endmodule

// File: tb/sv/sorted_relation_lookup_tb.sv
module sorted_relation_lookup_tb
   import srl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int              WATCHDOG_LIMIT = 4000;
   localparam int              SETTLE_CYCLES  = 200;
   localparam int              RESET_CYCLES   = 12;
   localparam int              SHORT_RUN      = 8;
   localparam int              WALK_W         = KEY_W + 1;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   int        send_idle_pct;
   int        recv_idle_pct;
   int        mismatches;
   int        outstanding;
   int        quiet_cycles;
   entry_type fwd_loaded [$];
   entry_type rev_loaded [$];

   srl_req_if req_bus ();
   srl_rsp_if rsp_bus ();

   sorted_relation_lookup dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   srl_lookup_checker u_lookup_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sorted_relation_lookup verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic entry_type random_entry();
      entry_type e;
      e.ga = GROUP_W'($urandom);
      e.gb = GROUP_W'($urandom);
      e.ia = INDEX_W'($urandom);
      e.ib = INDEX_W'($urandom);
      return e;
   endfunction

   // Offer one request after an optional gap and hold it until taken
   task automatic send_request(input logic [OP_W-1:0] code, input entry_type e);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_bus.valid   <= 1'b1;
      req_bus.op      <= code;
      req_bus.group_a <= e.ga;
      req_bus.group_b <= e.gb;
      req_bus.index_a <= e.ia;
      req_bus.index_b <= e.ib;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Hold off until every predicted response has been seen
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic clear_tables();
      send_request(OP_CLEAR, random_entry());
      fwd_loaded.delete();
      rev_loaded.delete();
   endtask

   // Load a run of entries in ascending key order, with duplicates and runs
   task automatic load_sorted(input bit by_target, input int count, input logic [KEY_W-1:0] start);
      logic [WALK_W-1:0] walk;
      entry_type         e;
      walk = {1'b0, start};
      for (int i = 0; i < count; i++) begin
         if (i > 0) begin
            case ($urandom_range(0, 9))
               0, 1:       ; // repeat the key
               2, 3, 4, 5: walk += WALK_W'($urandom_range(1, 3));
               6, 7, 8:    walk += WALK_W'($urandom_range(1, 4) << 8);
               default:    walk += WALK_W'($urandom_range(1, 1 << 24));
            endcase
            if (walk[KEY_W]) walk = {1'b0, {KEY_W{1'b1}}};
         end
         e = random_entry();
         if (by_target) begin
            e.gb = walk[31:24];
            e.ib = walk[23:8];
            e.ga = walk[7:0];
            send_request(OP_LOAD_REV, e);
            rev_loaded.push_back(e);
         end else begin
            e.ga = walk[31:24];
            e.ia = walk[23:8];
            e.gb = walk[7:0];
            send_request(OP_LOAD_FWD, e);
            fwd_loaded.push_back(e);
         end
      end
   endtask

   // Mostly hits on loaded keys, some near misses, some noise
   task automatic random_query();
      entry_type       e;
      entry_type       pick;
      bit              by_target;
      int              mode;
      logic [OP_W-1:0] code;
      by_target = 1'($urandom_range(0, 1));
      mode      = $urandom_range(0, 9);
      e         = random_entry();
      if (mode <= 6) begin
         if (by_target && rev_loaded.size() != 0) begin
            pick = rev_loaded[$urandom_range(0, rev_loaded.size() - 1)];
            e.gb = pick.gb;
            e.ib = pick.ib;
            e.ga = pick.ga;
         end else if (!by_target && fwd_loaded.size() != 0) begin
            pick = fwd_loaded[$urandom_range(0, fwd_loaded.size() - 1)];
            e.ga = pick.ga;
            e.ia = pick.ia;
            e.gb = pick.gb;
         end
         // nudge one key field to just miss
         if (mode >= 5) begin
            case ($urandom_range(0, 2))
               0:       e.ga += 8'd1;
               1:       e.gb -= 8'd1;
               default: if (by_target) e.ib += 16'd1; else e.ia -= 16'd1;
            endcase
         end
      end
      if (mode == 8) begin
         code = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         send_request(code, e);
      end else if (mode == 9) begin
         if ($urandom_range(0, 1)) send_request(by_target ? OP_LOAD_REV : OP_LOAD_FWD, e);
         else clear_tables();
      end else begin
         send_request(by_target ? OP_QUERY_REV : OP_QUERY_FWD, e);
      end
   endtask

   task automatic run_sequence();
      if ($urandom_range(0, 3) == 0) wait_for_results();
      if ($urandom_range(0, 3) != 0) clear_tables();
      load_sorted(1'b0, $urandom_range(1, 12), $urandom >> $urandom_range(0, 24));
      load_sorted(1'b1, $urandom_range(1, 12), $urandom >> $urandom_range(0, 24));
      repeat ($urandom_range(4, 10)) random_query();
   endtask

   task automatic directed_checks();
      entry_type       mid_e;
      logic [OP_W-1:0] code;
      mid_e = '{ga: 8'h80, gb: 8'h01, ia: 16'h1234, ib: 16'h8000};
      // lookups on empty tables
      send_request(OP_QUERY_FWD, '0);
      send_request(OP_QUERY_REV, '1);
      // extreme entries in both tables
      send_request(OP_LOAD_FWD, '0);
      send_request(OP_LOAD_FWD, '1);
      send_request(OP_LOAD_REV, '0);
      send_request(OP_LOAD_REV, '1);
      send_request(OP_QUERY_FWD, '0);
      send_request(OP_QUERY_FWD, '1);
      send_request(OP_QUERY_REV, '0);
      send_request(OP_QUERY_REV, '1);
      // key between the two entries
      send_request(OP_QUERY_FWD, mid_e);
      send_request(OP_QUERY_REV, mid_e);
      // spare codes produce nothing
      for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) begin
         code = OP_W'(c);
         send_request(code, random_entry());
      end
      // break the sort order and search anyway
      send_request(OP_LOAD_FWD, mid_e);
      send_request(OP_QUERY_FWD, mid_e);
      wait_for_results();
      // clear keeps contents but hides them
      send_request(OP_CLEAR, '1);
      send_request(OP_QUERY_FWD, '0);
      send_request(OP_LOAD_FWD, mid_e);
      send_request(OP_QUERY_FWD, mid_e);
   endtask

   // Runs longer than, equal to and shorter than the result cap
   task automatic long_runs();
      entry_type e;
      clear_tables();
      e = random_entry();
      for (int i = 0; i < MAX_RUN_DEF + 6; i++) begin
         e.gb = GROUP_W'(i * 3);
         e.ib = INDEX_W'($urandom);
         send_request(OP_LOAD_FWD, e);
         fwd_loaded.push_back(e);
      end
      e = random_entry();
      for (int i = 0; i < SHORT_RUN; i++) begin
         e.ga = GROUP_W'(i * 2);
         e.ia = INDEX_W'($urandom);
         send_request(OP_LOAD_REV, e);
         rev_loaded.push_back(e);
      end
      send_request(OP_QUERY_FWD, fwd_loaded[0]);
      send_request(OP_QUERY_FWD, fwd_loaded[6]);
      send_request(OP_QUERY_FWD, fwd_loaded[7]);
      send_request(OP_QUERY_REV, rev_loaded[0]);
      send_request(OP_QUERY_REV, rev_loaded[1]);
      repeat (6) random_query();
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.op      = OP_CLEAR;
      req_bus.group_a = '0;
      req_bus.group_b = '0;
      req_bus.index_a = '0;
      req_bus.index_b = '0;
      rsp_bus.ready   = 1'b0;
      quiet_cycles    = 0;
      send_idle_pct   = 13;
      recv_idle_pct   = 56;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver often stalled
      directed_checks();
      repeat (3) run_sequence();

      // sender often idle, receiver mostly ready
      send_idle_pct = 56;
      recv_idle_pct <= 13;
      repeat (3) run_sequence();
      long_runs();

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      repeat (2) run_sequence();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("sorted_relation_lookup verification clean");
      end else begin
         $display("sorted_relation_lookup verification failed");
      end
      $finish;
   end

endmodule
